### rtl/xor_linear_basis_top_assert.svh
// Assertion helpers for the basis top level; both expect clk and arst_n in scope.
`ifndef XOR_LINEAR_BASIS_TOP_ASSERT_SVH
`define XOR_LINEAR_BASIS_TOP_ASSERT_SVH

// same-cycle implication
`define XLB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define XLB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/xlb_pkg.sv
package xlb_pkg;

	localparam int VEC_FW  = 36;
	localparam int IDX_FW  = 6;
	localparam int RANK_FW = 6;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_QUERY  = 2'd1;
	localparam logic [1:0] OP_REDUCE = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	typedef struct packed {
		logic [1:0]        operation;
		logic [VEC_FW-1:0] vector_in;
		logic [IDX_FW-1:0] slot_index;
	} cmd_t;

	typedef struct packed {
		logic               flag;
		logic [RANK_FW-1:0] rank;
		logic [VEC_FW-1:0]  slot_value;
	} result_t;

endpackage

### rtl/xor_linear_basis_top.sv
// Channel   Ports                      Moves
// command   start, busy, cmd           one item in when start & !busy
// result    done, result               one item out, valid the cycle done is high
//
// Insert and query walk one pivot slot per cycle from the top.
// Reduce visits each slot below the top one as a pivot, from slot WIDTH-2 down, and, for every
// nonzero pivot i, each higher slot once.
// The pace is set by the single read port of the slot memory.
// Reset clears the slot valid bits at once; no clearing pass. The receiver cannot stall.
module xor_linear_basis_top #(
	parameter int WIDTH = 36
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  xlb_pkg::cmd_t  cmd,
	output logic           done,
	output xlb_pkg::result_t result
);
	import xlb_pkg::*;

	localparam int AW     = $clog2(WIDTH);
	localparam int RANK_W = $clog2(WIDTH + 1);
	localparam logic [AW-1:0] TOP_IDX = AW'(WIDTH - 1);
	localparam logic [AW-1:0] SUB_IDX = AW'(WIDTH - 2);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_WALK = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_RPIV = 3'd3;
	localparam logic [2:0] ST_RJ   = 3'd4;

	logic [2:0]        state_q, state_d;
	logic [1:0]        op_q;
	logic [WIDTH-1:0]  v_q, v_d;
	logic [WIDTH-1:0]  piv_q;
	logic [AW-1:0]     piv_idx_q;
	logic [AW-1:0]     rd_idx_q;
	logic              oor_q;
	logic [RANK_W-1:0] rank_q, rank_d;
	logic              done_q;
	result_t           result_q, result_d;

	logic              accept;
	logic              finish;
	logic              piv_load;
	logic              in_oor;
	logic              cur_bit;
	logic [WIDTH-1:0]  vin_w;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [WIDTH-1:0]  wr_data;
	logic [WIDTH-1:0]  slot;
	logic              slot_vld;

	xlb_slot_mem #(
		.WIDTH (WIDTH),
		.AW    (AW)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (rd_idx_q),
		.wr_data  (wr_data),
		.rd_addr  (rd_addr),
		.rd_data  (slot),
		.rd_valid (slot_vld)
	);

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign vin_w   = WIDTH'(cmd.vector_in);
	assign in_oor  = (7'(cmd.slot_index) >= 7'(WIDTH));
	assign cur_bit = v_q[rd_idx_q];

	always_comb begin
		state_d  = state_q;
		v_d      = v_q;
		rank_d   = rank_q;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_data  = v_q;
		finish   = 1'b0;
		piv_load = 1'b0;
		result_d = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					v_d = vin_w;
					case (cmd.operation)
						OP_INSERT, OP_QUERY: begin
							rd_addr = TOP_IDX;
							state_d = ST_WALK;
						end
						OP_REDUCE: begin
							rd_addr = SUB_IDX;
							state_d = ST_RPIV;
						end
						default: begin
							rd_addr = in_oor ? '0 : AW'(cmd.slot_index);
							state_d = ST_RD;
						end
					endcase
				end
			end
			ST_WALK: begin
				if (cur_bit && !slot_vld) begin
					// first empty pivot met: an insert stores the remainder here
					finish = 1'b1;
					if (op_q == OP_INSERT) begin
						wr_en         = 1'b1;
						rank_d        = rank_q + RANK_W'(1);
						result_d.flag = 1'b1;
					end
				end else begin
					if (cur_bit) begin
						v_d = v_q ^ slot;
					end
					if (rd_idx_q == '0) begin
						finish        = 1'b1;
						result_d.flag = (op_q == OP_QUERY);
					end else begin
						rd_addr = rd_idx_q - AW'(1);
					end
				end
			end
			ST_RD: begin
				finish              = 1'b1;
				result_d.slot_value = oor_q ? '0 : VEC_FW'(slot);
			end
			ST_RPIV: begin
				if (slot_vld) begin
					piv_load = 1'b1;
					rd_addr  = rd_idx_q + AW'(1);
					state_d  = ST_RJ;
				end else if (rd_idx_q == '0) begin
					finish = 1'b1;
				end else begin
					rd_addr = rd_idx_q - AW'(1);
				end
			end
			ST_RJ: begin
				wr_en   = slot_vld && slot[piv_idx_q];
				wr_data = slot ^ piv_q;
				if (rd_idx_q == TOP_IDX) begin
					if (piv_idx_q == '0) begin
						finish = 1'b1;
					end else begin
						rd_addr = piv_idx_q - AW'(1);
						state_d = ST_RPIV;
					end
				end else begin
					rd_addr = rd_idx_q + AW'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (finish) begin
			state_d = ST_IDLE;
		end
		result_d.rank = RANK_FW'(rank_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rank_q   <= '0;
			done_q   <= 1'b0;
			rd_idx_q <= '0;
		end else begin
			state_q  <= state_d;
			rank_q   <= rank_d;
			done_q   <= finish;
			rd_idx_q <= rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		v_q <= v_d;
		if (accept) begin
			op_q  <= cmd.operation;
			oor_q <= in_oor;
		end
		if (piv_load) begin
			piv_q     <= slot;
			piv_idx_q <= rd_idx_q;
		end
		if (finish) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

`include "xor_linear_basis_top_assert.svh"

	`XLB_ASSERT_NOW(a_done_idle, done_q, !busy, "result strobe while still busy")
	`XLB_ASSERT_NOW(a_rank_bound, 1'b1, rank_q <= RANK_W'(WIDTH), "rank beyond WIDTH")
	`XLB_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted item did not start work")
	`XLB_ASSERT_NOW(a_rank_step, done_q && result_q.flag && op_q == OP_INSERT,
		rank_q == $past(rank_q) + RANK_W'(1), "insert flagged without rank step")

endmodule

### rtl/xlb_slot_mem.sv
module xlb_slot_mem #(
	parameter int WIDTH = 36,
	parameter int AW    = $clog2(WIDTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	output logic             rd_valid
);

	logic [WIDTH-1:0] mem_q [WIDTH];
	logic [WIDTH-1:0] valid_q;
	logic [WIDTH-1:0] rd_data_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	// a slot never written reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign rd_valid = rd_valid_q;
	assign rd_data  = rd_valid_q ? rd_data_q : '0;

endmodule

### dv/tb_top.sv
module tb_top;
	import xlb_pkg::*;

	localparam int BASIS_W      = 36;
	localparam int HALF_PERIOD  = 4;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 64;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	cmd_t    cmd    = '0;
	logic    busy;
	logic    done;
	result_t result;

	xor_linear_basis_top #(.WIDTH(BASIS_W)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always #HALF_PERIOD clk = ~clk;

	cmd_t              pending_items[$];
	result_t           expected_results[$];
	logic [VEC_FW-1:0] pivot_model[BASIS_W];
	logic [VEC_FW-1:0] seen_vecs[$];
	int                model_rank   = 0;
	int                total_items  = 0;
	int                n_accepted   = 0;
	int                n_results    = 0;
	int                n_fail       = 0;
	int                n_added      = 0;
	int                n_in_span    = 0;
	int                n_reduce     = 0;
	int                n_read       = 0;
	int                peak_rank    = 0;
	int                idle_left    = 0;
	bit                idle_on      = 1'b1;
	int                quiet_cycles = 0;

	// mirror of the slot memory: walk, store, reduce, read
	function automatic result_t predict_basis(cmd_t c);
		result_t           r;
		logic [VEC_FW-1:0] v;
		int                stop_at;
		r       = '0;
		v       = c.vector_in;
		stop_at = -1;
		case (c.operation)
			OP_INSERT, OP_QUERY: begin
				for (int i = BASIS_W - 1; i >= 0; i--) begin
					if (v[i]) begin
						if (pivot_model[i] == '0) begin
							stop_at = i;
							break;
						end
						v ^= pivot_model[i];
					end
				end
				if (c.operation == OP_INSERT) begin
					if (stop_at >= 0) begin
						pivot_model[stop_at] = v;
						model_rank++;
						r.flag = 1'b1;
					end
				end else begin
					r.flag = (stop_at < 0);
				end
			end
			OP_REDUCE: begin
				for (int i = BASIS_W - 1; i >= 0; i--) begin
					if (pivot_model[i] != '0) begin
						for (int j = i + 1; j < BASIS_W; j++)
							if (pivot_model[j][i])
								pivot_model[j] ^= pivot_model[i];
					end
				end
			end
			default: begin
				if (c.slot_index < BASIS_W)
					r.slot_value = pivot_model[c.slot_index];
			end
		endcase
		r.rank = model_rank[RANK_FW-1:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [VEC_FW-1:0] rand_vec();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[VEC_FW-1:0];
	endfunction

	function automatic logic [IDX_FW-1:0] rand_idx();
		return IDX_FW'($urandom_range(0, 63));
	endfunction

	task automatic add_item(logic [1:0] op, logic [VEC_FW-1:0] v, logic [IDX_FW-1:0] idx);
		cmd_t c;
		c.operation  = op;
		c.vector_in  = v;
		c.slot_index = idx;
		pending_items = {pending_items, c};
		if (op == OP_INSERT)
			seen_vecs = {seen_vecs, v};
	endtask

	// mostly vectors built from earlier inserts, so the span grows slowly
	function automatic logic [VEC_FW-1:0] span_vec();
		logic [VEC_FW-1:0] v;
		int                terms;
		v = '0;
		if (seen_vecs.size() == 0 || $urandom_range(0, 99) < 25)
			return rand_vec() >> $urandom_range(0, VEC_FW - 1);
		terms = $urandom_range(1, 6);
		for (int k = 0; k < terms; k++)
			v ^= seen_vecs[$urandom_range(0, seen_vecs.size() - 1)];
		if ($urandom_range(0, 99) < 30)
			v[IDX_FW'($urandom_range(0, VEC_FW - 1))] ^= 1'b1;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin : drive
		bit      took;
		result_t want;
		if (!arst_n) begin
			start     <= 1'b0;
			cmd       <= '0;
			idle_left = 0;
		end else begin
			took = start && !busy;
			if (took) begin
				want = predict_basis(cmd);
				expected_results = {expected_results, want};
				n_accepted++;
				case (cmd.operation)
					OP_INSERT: n_added   += int'(want.flag);
					OP_QUERY:  n_in_span += int'(want.flag);
					OP_REDUCE: n_reduce++;
					default:   n_read++;
				endcase
				if (int'(want.rank) > peak_rank)
					peak_rank = int'(want.rank);
				if (n_accepted % 60 == 0)
					idle_on = ($urandom_range(0, 3) != 0);
				idle_left = pick_gap();
			end
			if (!start || took) begin
				if (idle_left > 0) begin
					idle_left--;
					start <= 1'b0;
				end else if (pending_items.size() > 0) begin
					start <= 1'b1;
					cmd   <= pending_items.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check
		result_t want;
		if (arst_n && done) begin
			n_results++;
			if (expected_results.size() == 0) begin
				$error("unexpected result: flag %0d rank %0d slot_value %h",
					result.flag, result.rank, result.slot_value);
				n_fail++;
			end else begin
				want = expected_results.pop_front();
				if (result.flag !== want.flag) begin
					$error("flag: expected %0d, got %0d", want.flag, result.flag);
					n_fail++;
				end
				if (result.rank !== want.rank) begin
					$error("rank: expected %0d, got %0d", want.rank, result.rank);
					n_fail++;
				end
				if (result.slot_value !== want.slot_value) begin
					$error("slot_value: expected %h, got %h", want.slot_value,
						result.slot_value);
					n_fail++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int          r;
		int          order[$];
		logic [5:0]  idx;
		for (int i = 0; i < BASIS_W; i++)
			pivot_model[i] = '0;

		// empty basis, zero vector, all-ones and single-bit vectors
		add_item(OP_READ,   '0, 6'd0);
		add_item(OP_QUERY,  '0, 6'd0);
		add_item(OP_INSERT, '0, 6'd0);
		add_item(OP_INSERT, 36'hF_FFFF_FFFF, 6'd63);
		add_item(OP_INSERT, 36'h0_0000_0001, 6'd0);
		add_item(OP_INSERT, 36'h8_0000_0000, 6'd35);
		add_item(OP_INSERT, 36'hF_FFFF_FFFF, 6'd0);
		add_item(OP_QUERY,  36'h7_FFFF_FFFF, 6'd0);
		add_item(OP_QUERY,  36'h0_0000_0002, 6'd0);
		add_item(OP_INSERT, 36'hA_AAAA_AAAA, 6'd21);
		add_item(OP_INSERT, 36'h5_5555_5555, 6'd42);
		add_item(OP_READ,   '0, 6'd35);
		add_item(OP_READ,   '0, 6'd34);
		add_item(OP_REDUCE, 36'hF_FFFF_FFFF, 6'd63);
		add_item(OP_READ,   '0, 6'd35);
		add_item(OP_READ,   '0, 6'd34);
		add_item(OP_READ,   '0, 6'd0);
		// indexes past the last slot read as zero
		add_item(OP_READ,   36'hF_FFFF_FFFF, 6'd36);
		add_item(OP_READ,   '0, 6'd63);
		add_item(OP_INSERT, 36'h8_0000_0001, 6'd0);
		add_item(OP_QUERY,  36'hF_FFFF_FFFF, 6'd0);
		add_item(OP_REDUCE, '0, 6'd0);
		add_item(OP_REDUCE, '0, 6'd0);
		add_item(OP_READ,   '0, 6'd35);

		for (int n = 0; n < 380; n++) begin
			r   = $urandom_range(0, 99);
			idx = (r % 4 == 0) ? rand_idx() : IDX_FW'($urandom_range(0, BASIS_W - 1));
			if (r < 40)
				add_item(OP_INSERT, span_vec(), rand_idx());
			else if (r < 75)
				add_item(OP_QUERY, span_vec(), rand_idx());
			else if (r < 88)
				add_item(OP_READ, rand_vec(), idx);
			else
				add_item(OP_REDUCE, rand_vec(), rand_idx());
		end

		// finish by filling every pivot with unit vectors in shuffled order
		for (int i = 0; i < BASIS_W; i++)
			order.push_front(BASIS_W - 1 - i);
		order.shuffle();
		foreach (order[k]) begin
			add_item(OP_INSERT, 36'h1 << order[k], rand_idx());
			if (k % 8 == 7)
				add_item(OP_QUERY, span_vec(), rand_idx());
		end
		add_item(OP_QUERY,  rand_vec(), 6'd0);
		add_item(OP_INSERT, rand_vec(), 6'd0);
		add_item(OP_REDUCE, '0, 6'd0);
		add_item(OP_READ,   '0, 6'd35);
		add_item(OP_READ,   '0, 6'd0);
		total_items = pending_items.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (n_accepted < total_items || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d commands, %0d results: %0d vectors added, %0d queries in span,",
			n_accepted, n_results, n_added, n_in_span);
		$display("%0d reduce passes, %0d slot reads, highest rank %0d of %0d",
			n_reduce, n_read, peak_rank, BASIS_W);
		if (n_fail == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
